// ===== rtl/ipp_request_attribute_parser_top_assert.svh =====
// assertion macros shared by the ipp request attribute parser rtl
`ifndef IPP_REQUEST_ATTRIBUTE_PARSER_TOP_ASSERT_SVH
`define IPP_REQUEST_ATTRIBUTE_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define IPPAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define IPPAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ippap_pkg.sv =====
// shared types, codes and name tables of the ipp request attribute parser
package ippap_pkg;

    // longest attribute name accepted before the record is flagged
    localparam logic [15:0] MAX_NAME_LEN = 16'd255;

    // byte classification codes
    localparam logic [3:0] KIND_HEADER    = 4'd0;
    localparam logic [3:0] KIND_GROUP_TAG = 4'd1;
    localparam logic [3:0] KIND_VALUE_TAG = 4'd2;
    localparam logic [3:0] KIND_LENGTH    = 4'd3;
    localparam logic [3:0] KIND_NAME      = 4'd4;
    localparam logic [3:0] KIND_VALUE     = 4'd5;
    localparam logic [3:0] KIND_END_TAG   = 4'd6;
    localparam logic [3:0] KIND_DOCUMENT  = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;

    // attribute select codes
    localparam logic [1:0] ATTR_OTHER     = 2'd0;
    localparam logic [1:0] ATTR_DOC_FMT   = 2'd1;
    localparam logic [1:0] ATTR_REQ_ATTRS = 2'd2;

    // status codes reported on the end tag
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_REQUEST = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND   = 2'd2;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

    // header version words
    localparam logic [15:0] VERSION_1_0 = 16'h0100;
    localparam logic [15:0] VERSION_1_1 = 16'h0101;
    localparam logic [15:0] VERSION_2_0 = 16'h0200;

    // delimiter tags
    localparam logic [7:0] TAG_OPERATION   = 8'h01;
    localparam logic [7:0] TAG_JOB         = 8'h02;
    localparam logic [7:0] TAG_END         = 8'h03;
    localparam logic [7:0] TAG_PRINTER     = 8'h04;
    localparam logic [7:0] TAG_UNSUPPORTED = 8'h05;

    // operation codes with a defined status
    localparam logic [15:0] OP_SUBMIT_DOC     = 16'd2;
    localparam logic [15:0] OP_CHECK_DOC      = 16'd4;
    localparam logic [15:0] OP_DROP_JOB       = 16'd8;
    localparam logic [15:0] OP_GET_JOB_ATTRS  = 16'd9;
    localparam logic [15:0] OP_LIST_JOBS      = 16'd10;
    localparam logic [15:0] OP_GET_PRT_ATTRS  = 16'd11;

    // minimum body size, the header alone
    localparam logic [31:0] HEADER_BYTES = 32'd8;

    // candidate attribute names
    localparam int FMT_LEN = 15;
    localparam int REQ_LEN = 20;
    localparam logic [8*FMT_LEN-1:0] FMT_NAME = "document-format";
    localparam logic [8*REQ_LEN-1:0] REQ_NAME = "requested-attributes";

    // one item on the input side
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_message;
        logic [31:0] body_length;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [3:0]  byte_kind;
        logic [7:0]  byte_echo;
        logic [1:0]  attribute_select;
        logic [15:0] ipp_version;
        logic [15:0] operation_id;
        logic [31:0] request_number;
        logic [31:0] document_bytes;
        logic [1:0]  status_code;
        logic        malformed;
        logic        last;
    } t_result;

    // character of "document-format" at a position below FMT_LEN
    function automatic logic [7:0] fmt_char(input logic [7:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < FMT_LEN; k++) begin
            if (idx == 8'(k)) begin
                c = FMT_NAME[8*(FMT_LEN-1-k) +: 8];
            end
        end
        return c;
    endfunction

    // character of "requested-attributes" at a position below REQ_LEN
    function automatic logic [7:0] req_char(input logic [7:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < REQ_LEN; k++) begin
            if (idx == 8'(k)) begin
                c = REQ_NAME[8*(REQ_LEN-1-k) +: 8];
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/ippap_in_stage.sv =====
// input register of the ipp request attribute parser
module ippap_in_stage
    import ippap_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    // hold the input while the held item cannot move on
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture on each transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/ippap_core.sv =====
// per-byte parser state and classification logic
`include "ipp_request_attribute_parser_top_assert.svh"
module ippap_core
    import ippap_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_result  o_result
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TAG,
        PH_NLEN_HI,
        PH_NLEN_LO,
        PH_NAME,
        PH_VLEN_HI,
        PH_VLEN_LO,
        PH_VALUE,
        PH_DOC,
        PH_ERR
    } t_phase;

    // bytes of the body still to come replace a used count and a length
    t_phase      r_phase,      n_phase;
    logic [31:0] r_remaining,  n_remaining;
    logic [2:0]  r_hdr_pos,    n_hdr_pos;
    logic [15:0] r_version,    n_version;
    logic [15:0] r_operation,  n_operation;
    logic [31:0] r_request,    n_request;
    logic [15:0] r_field_rem,  n_field_rem;
    logic [7:0]  r_length_hi,  n_length_hi;
    logic [7:0]  r_name_pos,   n_name_pos;
    logic [1:0]  r_name_match, n_name_match;
    logic [1:0]  r_cur_attr,   n_cur_attr;
    logic [1:0]  r_prev_attr,  n_prev_attr;

    function automatic logic [1:0] status_for(input logic [15:0] op, input logic no_doc);
        logic [1:0] s;
        if (op == OP_SUBMIT_DOC) begin
            s = no_doc ? STATUS_BAD_REQUEST : STATUS_OK;
        end else if (op == OP_CHECK_DOC || op == OP_LIST_JOBS || op == OP_GET_PRT_ATTRS) begin
            s = STATUS_OK;
        end else if (op == OP_DROP_JOB || op == OP_GET_JOB_ATTRS) begin
            s = STATUS_NOT_FOUND;
        end else begin
            s = STATUS_UNSUPPORTED;
        end
        return s;
    endfunction

    // one byte step: start clearing, then the phase decision
    always_comb begin
        logic [7:0]  b;
        logic [31:0] rem_eff;
        logic [15:0] len16;
        logic [1:0]  m;
        logic [15:0] fr_dec;
        logic [3:0]  kind;
        logic [1:0]  sel;
        logic [1:0]  st;
        logic [31:0] docb;
        logic        lastf;

        b = i_item.data_byte;

        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_hdr_pos    = r_hdr_pos;
        n_version    = r_version;
        n_operation  = r_operation;
        n_request    = r_request;
        n_field_rem  = r_field_rem;
        n_length_hi  = r_length_hi;
        n_name_pos   = r_name_pos;
        n_name_match = r_name_match;
        n_cur_attr   = r_cur_attr;
        n_prev_attr  = r_prev_attr;

        // start of a message clears everything and samples the length
        if (i_item.start_of_message) begin
            n_phase      = (i_item.body_length < HEADER_BYTES) ? PH_ERR : PH_HEADER;
            n_remaining  = i_item.body_length;
            n_hdr_pos    = 3'd0;
            n_version    = 16'd0;
            n_operation  = 16'd0;
            n_request    = 32'd0;
            n_field_rem  = 16'd0;
            n_length_hi  = 8'd0;
            n_name_pos   = 8'd0;
            n_name_match = 2'b11;
            n_cur_attr   = ATTR_OTHER;
            n_prev_attr  = ATTR_OTHER;
        end

        rem_eff = n_remaining;
        len16   = {n_length_hi, b};
        m       = n_name_match;
        fr_dec  = n_field_rem - 16'd1;
        kind    = KIND_ERROR;
        sel     = ATTR_OTHER;
        st      = STATUS_OK;
        docb    = 32'd0;
        lastf   = 1'b0;

        if (rem_eff != 32'd0) begin
            n_remaining = rem_eff - 32'd1;
            lastf       = (rem_eff == 32'd1);
            case (n_phase)
                PH_HEADER: begin
                    kind = KIND_HEADER;
                    // header byte placed by its position, then the position moves on
                    case (n_hdr_pos)
                        3'd0: n_version   = {b, 8'h00};
                        3'd1: n_version   = {n_version[15:8], b};
                        3'd2: n_operation = {b, 8'h00};
                        3'd3: n_operation = {n_operation[15:8], b};
                        3'd4: n_request   = {b, 24'h000000};
                        3'd5: n_request   = {n_request[31:24], b, 16'h0000};
                        3'd6: n_request   = {n_request[31:16], b, 8'h00};
                        default: begin
                            n_request = {n_request[31:8], b};
                            if (n_version != VERSION_1_0 && n_version != VERSION_1_1 &&
                                n_version != VERSION_2_0) begin
                                n_version = VERSION_1_1;
                            end
                            n_phase = PH_TAG;
                        end
                    endcase
                    n_hdr_pos = n_hdr_pos + 3'd1;
                end
                PH_TAG: begin
                    if (b == TAG_END) begin
                        kind    = KIND_END_TAG;
                        docb    = rem_eff - 32'd1;
                        st      = status_for(n_operation, rem_eff == 32'd1);
                        n_phase = PH_DOC;
                    end else if (b == TAG_OPERATION || b == TAG_JOB ||
                                 b == TAG_PRINTER || b == TAG_UNSUPPORTED) begin
                        kind        = KIND_GROUP_TAG;
                        n_prev_attr = ATTR_OTHER;
                    end else begin
                        kind    = KIND_VALUE_TAG;
                        n_phase = PH_NLEN_HI;
                    end
                end
                PH_NLEN_HI: begin
                    kind        = KIND_LENGTH;
                    n_length_hi = b;
                    n_phase     = PH_NLEN_LO;
                end
                PH_NLEN_LO: begin
                    // name plus both value length bytes must fit in the body
                    if (len16 > MAX_NAME_LEN ||
                        ({17'd0, len16} + 33'd3) > {1'b0, rem_eff}) begin
                        n_phase = PH_ERR;
                    end else begin
                        kind = KIND_LENGTH;
                        if (len16 == 16'd0) begin
                            n_cur_attr = n_prev_attr;
                            n_phase    = PH_VLEN_HI;
                        end else begin
                            n_field_rem  = len16;
                            n_name_pos   = 8'd0;
                            n_name_match = 2'b11;
                            n_phase      = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    kind = KIND_NAME;
                    if (n_name_pos >= 8'(FMT_LEN) || fmt_char(n_name_pos) != b) begin
                        m = m & 2'b10;
                    end
                    if (n_name_pos >= 8'(REQ_LEN) || req_char(n_name_pos) != b) begin
                        m = m & 2'b01;
                    end
                    n_name_match = m;
                    if (n_name_pos != 8'hFF) begin
                        n_name_pos = n_name_pos + 8'd1;
                    end
                    n_field_rem = fr_dec;
                    if (fr_dec == 16'd0) begin
                        if (m[0] && n_name_pos == 8'(FMT_LEN)) begin
                            n_cur_attr = ATTR_DOC_FMT;
                        end else if (m[1] && n_name_pos == 8'(REQ_LEN)) begin
                            n_cur_attr = ATTR_REQ_ATTRS;
                        end else begin
                            n_cur_attr = ATTR_OTHER;
                        end
                        n_prev_attr = n_cur_attr;
                        n_phase     = PH_VLEN_HI;
                    end
                end
                PH_VLEN_HI: begin
                    kind        = KIND_LENGTH;
                    n_length_hi = b;
                    n_phase     = PH_VLEN_LO;
                end
                PH_VLEN_LO: begin
                    // the value must fit in what is left after this byte
                    if ({16'd0, len16} >= rem_eff) begin
                        n_phase = PH_ERR;
                    end else begin
                        kind        = KIND_LENGTH;
                        n_field_rem = len16;
                        n_phase     = (len16 == 16'd0) ? PH_TAG : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    kind        = KIND_VALUE;
                    sel         = n_cur_attr;
                    n_field_rem = fr_dec;
                    if (fr_dec == 16'd0) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_DOC: begin
                    kind = KIND_DOCUMENT;
                end
                default: begin
                    n_phase = PH_ERR;
                end
            endcase

            // body ended before the end tag
            if (lastf && n_phase != PH_DOC) begin
                n_phase = PH_ERR;
            end
            if (n_phase == PH_ERR) begin
                kind = KIND_ERROR;
                sel  = ATTR_OTHER;
                st   = STATUS_OK;
                docb = 32'd0;
            end
        end

        o_result.byte_kind        = kind;
        o_result.byte_echo        = b;
        o_result.attribute_select = sel;
        o_result.ipp_version      = n_version;
        o_result.operation_id     = n_operation;
        o_result.request_number   = n_request;
        o_result.document_bytes   = docb;
        o_result.status_code      = st;
        o_result.malformed        = (kind == KIND_ERROR);
        o_result.last             = lastf;
    end

    // parser state, advanced once per transfer into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_remaining  <= 32'd0;
            r_hdr_pos    <= 3'd0;
            r_version    <= 16'd0;
            r_operation  <= 16'd0;
            r_request    <= 32'd0;
            r_field_rem  <= 16'd0;
            r_length_hi  <= 8'd0;
            r_name_pos   <= 8'd0;
            r_name_match <= 2'b11;
            r_cur_attr   <= ATTR_OTHER;
            r_prev_attr  <= ATTR_OTHER;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_hdr_pos    <= n_hdr_pos;
            r_version    <= n_version;
            r_operation  <= n_operation;
            r_request    <= n_request;
            r_field_rem  <= n_field_rem;
            r_length_hi  <= n_length_hi;
            r_name_pos   <= n_name_pos;
            r_name_match <= n_name_match;
            r_cur_attr   <= n_cur_attr;
            r_prev_attr  <= n_prev_attr;
        end
    end

    // end tag moves the parser into the document section
    `IPPAP_ASSERT_NXT(a_end_to_doc, i_clk, i_rst_n,
        i_fire && o_result.byte_kind == KIND_END_TAG, r_phase == PH_DOC,
        "end tag did not enter document phase")
    // the last body byte leaves the parser only in document or error phase
    `IPPAP_ASSERT_NXT(a_last_settles, i_clk, i_rst_n,
        i_fire && o_result.last, r_phase == PH_DOC || r_phase == PH_ERR,
        "last byte left parser in an open phase")
    // a status is reported only on the end tag
    `IPPAP_ASSERT_IMP(a_status_on_end, i_clk, i_rst_n,
        i_fire && o_result.status_code != STATUS_OK, o_result.byte_kind == KIND_END_TAG,
        "status reported outside end tag")
    // past the body end nothing is consumed until a new start
    `IPPAP_ASSERT_NXT(a_body_exhausted, i_clk, i_rst_n,
        i_fire && !i_item.start_of_message && r_remaining == 32'd0, r_remaining == 32'd0,
        "byte count moved past the body end")

endmodule

// ===== rtl/ippap_out_stage.sv =====
// result register of the ipp request attribute parser
module ippap_out_stage
    import ippap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    w_load;

    // register frees up when empty or when its result transfers out
    assign o_ready = !r_valid || !i_stall;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        if (w_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/ipp_request_attribute_parser_top.sv =====
// top level of the ipp request attribute parser
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------------------
//   input    | in        | i_in_valid / o_in_stall | data_byte, start_of_message, body_length
//   result   | out       | o_out_valid/ i_out_stall| byte_kind .. last, one per input byte
//
// one byte per cycle sustained while the result side does not stall; a byte's result passes
// through the input register, then the single-pass parse logic into the result register,
// and is shown on the outputs from the result register
// synchronous active-low reset clears the valid flags of both registers and the parser state
// after reset every byte is flagged as an error until a start of message
// a stalled result holds in its register while the input register takes one more byte
module ipp_request_attribute_parser_top
    import ippap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_message,
    input  logic [31:0] i_body_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_byte_kind,
    output logic [7:0]  o_byte_echo,
    output logic [1:0]  o_attribute_select,
    output logic [15:0] o_ipp_version,
    output logic [15:0] o_operation_id,
    output logic [31:0] o_request_number,
    output logic [31:0] o_document_bytes,
    output logic [1:0]  o_status_code,
    output logic        o_malformed,
    output logic        o_last
);

    t_in_item w_in_item;
    t_in_item w_held_item;
    logic     w_held_valid;
    logic     w_out_ready;
    logic     w_fire;
    t_result  w_step_result;
    t_result  w_out_result;

    assign w_in_item.data_byte        = i_data_byte;
    assign w_in_item.start_of_message = i_start_of_message;
    assign w_in_item.body_length      = i_body_length;

    // a held byte is parsed when the result register can take it
    assign w_fire = w_held_valid && w_out_ready;

    ippap_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (w_in_item),
        .i_advance (w_out_ready),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    ippap_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_held_item),
        .o_result (w_step_result)
    );

    ippap_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_held_valid),
        .i_result (w_step_result),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out_result)
    );

    // result fields onto their ports
    assign o_byte_kind        = w_out_result.byte_kind;
    assign o_byte_echo        = w_out_result.byte_echo;
    assign o_attribute_select = w_out_result.attribute_select;
    assign o_ipp_version      = w_out_result.ipp_version;
    assign o_operation_id     = w_out_result.operation_id;
    assign o_request_number   = w_out_result.request_number;
    assign o_document_bytes   = w_out_result.document_bytes;
    assign o_status_code      = w_out_result.status_code;
    assign o_malformed        = w_out_result.malformed;
    assign o_last             = w_out_result.last;

endmodule
